[rtl/rtcoc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcoc_pkg: shared types and constants of the compare channel timer
// Widths, command codes, register indexes and the channel bank request and
// status structures.
// ----------------------------------------------------------------------------
package rtcoc_pkg;

  // Number of compare channels and width of the prescaled counter.
  localparam int CHANNELS     = 4;
  localparam int COUNTER_BITS = 24;

  // Channel index and scan counter widths.
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CNT_W = $clog2(CHANNELS + 1);

  // Field and register widths.
  localparam int CMD_W      = 3;
  localparam int DELAY_W    = 16;
  localparam int PRESCALE_W = 13;
  localparam int PHASE_W    = 12;
  localparam int TPM_W      = 11;
  localparam int MIND_W     = 16;
  localparam int WRAP_W     = 8;
  localparam int USER_W     = 8;
  localparam int SPAN_W     = DELAY_W + TPM_W;
  localparam int NOW_W      = 32;
  localparam int EXT_W      = WRAP_W + COUNTER_BITS;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Stream payload widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Prescaler clamp limits.
  localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = PRESCALE_W'(4096);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ARM     = 3'd1,
    CMD_READ    = 3'd2,
    CMD_ACQUIRE = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_t;

  // Register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PRESCALE = 2'd0,
    REG_TPM      = 2'd1,
    REG_MIN_DLY  = 2'd2
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Request from the sequencer to the channel bank.
  typedef struct packed {
    logic [CH_IDX_W-1:0]     idx;
    logic                    clr;
    logic                    set;
    logic [COUNTER_BITS-1:0] cmp_val;
  } chan_req_t;

  // Status of the addressed channel.
  typedef struct packed {
    logic busy;
    logic match;
  } chan_stat_t;

  // Extended time: overflow count above the counter, modulo 2^32.
  function automatic logic [NOW_W-1:0] ext_time(input logic [WRAP_W-1:0] wrap,
                                                input logic [COUNTER_BITS-1:0] cnt);
    logic [EXT_W-1:0] t;
    t = {wrap, cnt};
    return t[NOW_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/rtcoc_chan_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcoc_chan_bank: compare channel storage with one shared comparator
// Holds the busy flags and compare values; the addressed channel is compared
// against the counter, so a full check walks the channels one per cycle.
// ----------------------------------------------------------------------------
module rtcoc_chan_bank (
  input  wire                                clk,
  input  wire                                rst_n,
  input  rtcoc_pkg::chan_req_t               req,
  input  wire [rtcoc_pkg::COUNTER_BITS-1:0]  count_value,
  output rtcoc_pkg::chan_stat_t              stat
);
  import rtcoc_pkg::*;

  logic [CHANNELS-1:0]     busy_r;
  logic [COUNTER_BITS-1:0] cmp_r [CHANNELS];

  // Busy flags: cleared on reset, set on arm and cleared on firing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (req.set) begin
      busy_r[req.idx] <= 1'b1;
    end else if (req.clr) begin
      busy_r[req.idx] <= 1'b0;
    end
  end

  // Compare values are written only when a channel is armed.
  always_ff @(posedge clk) begin
    if (req.set) begin
      cmp_r[req.idx] <= req.cmp_val;
    end
  end

  // Shared equality comparator on the addressed channel.
  always_comb begin
    stat.busy  = busy_r[req.idx];
    stat.match = busy_r[req.idx] && (cmp_r[req.idx] == count_value);
  end

endmodule
`default_nettype wire

[rtl/rtc_one_shot_compare_channels_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_one_shot_compare_channels_core: real-time counter with one-shot compares
// Prescaled 24-bit counter with an overflow count, reference-counted run
// state and a small bank of one-shot compare channels.
// ----------------------------------------------------------------------------
// Flow: an accepted command goes through the execute state, then, for an
// advancing tick or an arm, through the channel scan, as one shared comparator
// scans the channels, and then the result state, which loads the result register.
// Throughput: one command at a time; the next transaction is taken only after the
// result state has handed on its result, and later still while the result waits.
// Reset (synchronous, active low) stops the counter, frees every channel and loads defaults.
module rtc_one_shot_compare_channels_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Configuration write port
  input  wire                                 cfg_we,
  input  wire [rtcoc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire [rtcoc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Command stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: cmd[2:0], delay[18:3], zero fill[23:19]
  input  wire [rtcoc_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // Fields from bit 0: ok[0], channel[2:1], fired_mask[6:3],
  // now_count[38:7], running[39]
  output logic [rtcoc_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import rtcoc_pkg::*;

  // Configuration registers.
  logic [PRESCALE_W-1:0] prescale_r;
  logic [TPM_W-1:0]      tpm_r;
  logic [MIND_W-1:0]     mind_r;

  // Timer state.
  logic [COUNTER_BITS-1:0] count_r, count_nxt;
  logic [WRAP_W-1:0]       wrap_r, wrap_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic [USER_W-1:0]       user_r, user_nxt;
  logic                    run_r, run_nxt;

  // Sequencer and working registers.
  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [DELAY_W-1:0]    delay_r, delay_nxt;
  logic [SPAN_W-1:0]     span_r, span_nxt;
  logic [CH_CNT_W-1:0]   scan_r, scan_nxt;
  logic                  ok_r, ok_nxt;
  logic [CH_IDX_W-1:0]   chan_r, chan_nxt;
  logic [CHANNELS-1:0]   fired_r, fired_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Helpers.
  logic [PRESCALE_W-1:0] div_eff;
  logic [PRESCALE_W-1:0] phase_inc;
  logic [DELAY_W-1:0]    eff_delay;
  logic [CH_IDX_W-1:0]   scan_idx;
  logic                  last_scan;
  logic [COUNTER_BITS-1:0] arm_base;
  logic [1:0]            chan_ext;
  logic [3:0]            fired_ext;
  chan_req_t             bank_req;
  chan_stat_t            bank_stat;

  rtcoc_chan_bank u_bank (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (bank_req),
    .count_value (count_r),
    .stat        (bank_stat)
  );

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_W'(1);
      tpm_r      <= TPM_W'(32);
      mind_r     <= MIND_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRESCALE: prescale_r <= cfg_wdata[PRESCALE_W-1:0];
        REG_TPM:      tpm_r      <= cfg_wdata[TPM_W-1:0];
        REG_MIN_DLY:  mind_r     <= cfg_wdata[MIND_W-1:0];
        default:      ;
      endcase
    end
  end

  // Prescale divisor clamped to its usable range.
  always_comb begin
    if (prescale_r == '0) begin
      div_eff = PRESCALE_W'(1);
    end else if (prescale_r > PRESCALE_MAX) begin
      div_eff = PRESCALE_MAX;
    end else begin
      div_eff = prescale_r;
    end
  end

  assign phase_inc = {1'b0, phase_r} + PRESCALE_W'(1);
  assign eff_delay = (delay_r < mind_r) ? mind_r : delay_r;
  assign scan_idx  = scan_r[CH_IDX_W-1:0];
  assign last_scan = (scan_r == CH_CNT_W'(CHANNELS - 1));
  // An arm that is the first user restarts the counter from zero.
  assign arm_base  = (user_r == '0) ? '0 : count_r;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      wrap_r      <= '0;
      phase_r     <= '0;
      user_r      <= '0;
      run_r       <= 1'b0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wrap_r      <= wrap_nxt;
      phase_r     <= phase_nxt;
      user_r      <= user_nxt;
      run_r       <= run_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    delay_r    <= delay_nxt;
    span_r     <= span_nxt;
    ok_r       <= ok_nxt;
    chan_r     <= chan_nxt;
    fired_r    <= fired_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state and command execution.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wrap_nxt      = wrap_r;
    phase_nxt     = phase_r;
    user_nxt      = user_r;
    run_nxt       = run_r;
    cmd_nxt       = cmd_r;
    delay_nxt     = delay_r;
    span_nxt      = span_r;
    scan_nxt      = scan_r;
    ok_nxt        = ok_r;
    chan_nxt      = chan_r;
    fired_nxt     = fired_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    chan_ext      = 2'(chan_r);
    fired_ext     = 4'(fired_r);

    bank_req         = '0;
    bank_req.idx     = scan_idx;
    bank_req.cmp_val = arm_base + COUNTER_BITS'(span_r);

    unique case (state_r)
      // Wait for a command transaction.
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = in_tdata[CMD_W-1:0];
          delay_nxt = in_tdata[CMD_W+DELAY_W-1:CMD_W];
          ok_nxt    = 1'b0;
          chan_nxt  = '0;
          fired_nxt = '0;
          scan_nxt  = '0;
          state_nxt = ST_EXEC;
        end
      end

      // Decode the command and do the single-step work.
      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (cmd_r)
          CMD_TICK: begin
            ok_nxt = 1'b1;
            if (run_r) begin
              if (phase_inc < div_eff) begin
                phase_nxt = phase_inc[PHASE_W-1:0];
              end else begin
                phase_nxt = '0;
                count_nxt = count_r + COUNTER_BITS'(1);
                if (count_nxt == '0) begin
                  wrap_nxt = wrap_r + WRAP_W'(1);
                end
                state_nxt = ST_SCAN;
              end
            end
          end
          CMD_ARM: begin
            span_nxt  = SPAN_W'(eff_delay) * SPAN_W'(tpm_r);
            state_nxt = ST_SCAN;
          end
          CMD_READ: begin
            ok_nxt = 1'b1;
          end
          CMD_ACQUIRE: begin
            ok_nxt = 1'b1;
            if (user_r == '0) begin
              count_nxt = '0;
              wrap_nxt  = '0;
              phase_nxt = '0;
              run_nxt   = 1'b1;
            end
            if (user_r != '1) begin
              user_nxt = user_r + USER_W'(1);
            end
          end
          CMD_RELEASE: begin
            if (user_r != '0) begin
              ok_nxt   = 1'b1;
              user_nxt = user_r - USER_W'(1);
              if (user_r == USER_W'(1)) begin
                run_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end

      // Walk the channels through the shared comparator.
      ST_SCAN: begin
        scan_nxt = scan_r + CH_CNT_W'(1);
        if (last_scan) begin
          state_nxt = ST_DONE;
        end
        if (cmd_r == CMD_TICK) begin
          // Fire: free the channel and drop one user.
          if (bank_stat.match) begin
            bank_req.clr = 1'b1;
            fired_nxt    = fired_r | (CHANNELS'(1) << scan_idx);
            if (user_r != '0) begin
              user_nxt = user_r - USER_W'(1);
              if (user_r == USER_W'(1)) begin
                run_nxt = 1'b0;
              end
            end
          end
        end else if (!bank_stat.busy) begin
          // Arm the lowest free channel.
          bank_req.set = 1'b1;
          ok_nxt       = 1'b1;
          chan_nxt     = scan_idx;
          state_nxt    = ST_DONE;
          if (user_r == '0) begin
            count_nxt = '0;
            wrap_nxt  = '0;
            phase_nxt = '0;
            run_nxt   = 1'b1;
          end
          if (user_r != '1) begin
            user_nxt = user_r + USER_W'(1);
          end
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {run_r, ext_time(wrap_r, count_r), fired_ext, chan_ext, ok_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The counter runs only while it has at least one user.
  a_run_has_user: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (user_r != '0))
    else $error("counter running without a user");

  // The channel scan never runs past the last channel.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r < CH_CNT_W'(CHANNELS)))
    else $error("channel scan out of range");

  // A result that reports firing always reports success.
  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[6:3] != '0)) |-> out_data_r[0])
    else $error("fired mask on a failed command");

  // Leaving the scan always means a result is next.
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && last_scan) |=> (state_r == ST_DONE))
    else $error("scan did not end in the result state");

endmodule
`default_nettype wire

[verif/tb_rtc_one_shot_compare_channels_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtc_one_shot_compare_channels_core: self-checking bench for the RTC core
// Drives timer commands over the input stream and compares every reply with
// a cycle-free timer predictor kept in step at each accepted transaction.
// A directed table covers the reset state, the error replies and a full
// stop-restart-fire sequence. Randomised phases under several prescaler,
// tick rate and minimum delay settings follow, with idle bursts on both
// sides, a long result hold-off and a user count saturation run.
// ----------------------------------------------------------------------------
module tb_rtc_one_shot_compare_channels_core;
  import rtcoc_pkg::*;

  // Command codes with no operation behind them.
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
  // Worst-case reply latency of one command.
  localparam int REPLY_LATENCY = 3 + CHANNELS;
  // At 1024 increments per ms this many ms span one whole counter period.
  localparam int WRAP_MS = 16384;

  typedef enum int {
    DLY_UP_TO_31,
    DLY_UP_TO_15,
    DLY_ANY,
    DLY_WRAPPING
  } delay_mix_t;

  // Reply fields, laid out as on out_tdata (ok in bit 0).
  typedef struct packed {
    logic              running;
    logic [NOW_W-1:0]  now;
    logic [3:0]        fired;
    logic [1:0]        chan;
    logic              ok;
  } reply_t;

  typedef struct {
    bit                    is_reg;
    reg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [CMD_W-1:0]      op;
    logic [DELAY_W-1:0]    dly;
    bit                    typed;
    reply_t                want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  reg_idx_t              cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // Fields from bit 0: cmd[2:0], delay[18:3], zero fill[23:19]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // Fields from bit 0: ok[0], channel[2:1], fired_mask[6:3],
  // now_count[38:7], running[39]
  logic [OUT_DATA_W-1:0] out_tdata;

  reply_t      replies_due[$];
  script_row_t script[$];
  int          error_count = 0;
  int          replies_seen = 0;
  bit          long_hold_done = 1'b0;
  bit          calm = 1'b0;

  // Timer state as the predictor sees it.
  logic [COUNTER_BITS-1:0] rtc_count = '0;
  logic [WRAP_W-1:0]       rtc_wraps = '0;
  int                      rtc_phase = 0;
  int                      rtc_users = 0;
  logic                    rtc_running = 1'b0;
  logic                    chan_busy [CHANNELS] = '{default: 1'b0};
  logic [COUNTER_BITS-1:0] chan_cmp [CHANNELS];
  logic [PRESCALE_W-1:0]   cur_div = 1;
  logic [TPM_W-1:0]        cur_tpm = 32;
  logic [MIND_W-1:0]       cur_min = 1;

  rtc_one_shot_compare_channels_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // The first user restarts the counter from zero.
  function automatic void add_user();
    if (rtc_users == 0) begin
      rtc_count   = '0;
      rtc_wraps   = '0;
      rtc_phase   = 0;
      rtc_running = 1'b1;
    end
    if (rtc_users < 255) rtc_users++;
  endfunction

  function automatic void drop_user();
    if (rtc_users > 0) begin
      rtc_users--;
      if (rtc_users == 0) rtc_running = 1'b0;
    end
  endfunction

  // One raw tick: prescale, count, then fire every matching busy channel.
  function automatic logic [3:0] advance_tick();
    int         div;
    logic [3:0] mask;
    mask = '0;
    if (!rtc_running) return mask;
    div = cur_div;
    if (div == 0) div = 1;
    if (div > 4096) div = 4096;
    rtc_phase++;
    if (rtc_phase < div) return mask;
    rtc_phase = 0;
    rtc_count++;
    if (rtc_count == '0) rtc_wraps++;
    for (int i = 0; i < CHANNELS; i++) begin
      if (chan_busy[i] && chan_cmp[i] == rtc_count) begin
        chan_busy[i] = 1'b0;
        mask[i]      = 1'b1;
        drop_user();
      end
    end
    return mask;
  endfunction

  function automatic reply_t predict_reply(logic [CMD_W-1:0] op, logic [DELAY_W-1:0] dly);
    reply_t            r;
    logic [SPAN_W-1:0] span;
    bit                taken;
    r     = '0;
    taken = 1'b0;
    case (op)
      CMD_TICK: begin
        r.fired = advance_tick();
        r.ok    = 1'b1;
      end
      CMD_ARM: begin
        // The lowest free channel takes the compare; none free is a failure.
        for (int i = 0; i < CHANNELS; i++) begin
          if (!taken && !chan_busy[i]) begin
            if (dly < cur_min) dly = cur_min;
            add_user();
            span         = dly * cur_tpm;
            chan_cmp[i]  = rtc_count + span[COUNTER_BITS-1:0];
            chan_busy[i] = 1'b1;
            r.chan       = 2'(i);
            r.ok         = 1'b1;
            taken        = 1'b1;
          end
        end
      end
      CMD_READ: r.ok = 1'b1;
      CMD_ACQUIRE: begin
        add_user();
        r.ok = 1'b1;
      end
      CMD_RELEASE: begin
        if (rtc_users > 0) begin
          drop_user();
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.now     = {rtc_wraps, rtc_count};
    r.running = rtc_running;
    return r;
  endfunction

  // ----------------------------------------------------------------- stimulus

  // Offers one command, records its predicted reply once accepted, and may
  // then leave a short gap on the input.
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [DELAY_W-1:0] dly,
                          input bit typed, input reply_t want);
    reply_t guess;
    in_tdata  <= IN_DATA_W'({dly, op});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = predict_reply(op, dly);
    replies_due.push_back(typed ? want : guess);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every reply has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PRESCALE: cur_div = val[PRESCALE_W-1:0];
      REG_TPM:      cur_tpm = val[TPM_W-1:0];
      default:      cur_min = val;
    endcase
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] div, input logic [CFG_DATA_W-1:0] tpm,
                            input logic [CFG_DATA_W-1:0] min_ms);
    settle();
    write_reg(REG_PRESCALE, div);
    write_reg(REG_TPM, tpm);
    write_reg(REG_MIN_DLY, min_ms);
  endtask

  function automatic script_row_t op_row(logic [CMD_W-1:0] op, logic [DELAY_W-1:0] dly);
    script_row_t r;
    r.is_reg  = 1'b0;
    r.reg_idx = REG_PRESCALE;
    r.reg_val = '0;
    r.op      = op;
    r.dly     = dly;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  // A row whose reply is known outright: no channel, nothing fired.
  function automatic script_row_t typed_row(logic [CMD_W-1:0] op, logic [DELAY_W-1:0] dly,
                                            logic ok, logic [NOW_W-1:0] now, logic running);
    script_row_t r;
    r              = op_row(op, dly);
    r.typed        = 1'b1;
    r.want.ok      = ok;
    r.want.now     = now;
    r.want.running = running;
    return r;
  endfunction

  function automatic script_row_t reg_row(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    script_row_t r;
    r         = op_row(CMD_READ, '0);
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay(delay_mix_t mix);
    int pick;
    case (mix)
      DLY_UP_TO_31: return DELAY_W'($urandom_range(0, 31));
      DLY_UP_TO_15: return DELAY_W'($urandom_range(0, 15));
      DLY_ANY:      return DELAY_W'($urandom);
      default: begin
        // Whole counter periods, so the compare lands back on the counter;
        // a request below the minimum is raised to one period.
        pick = $urandom_range(0, 4);
        if (pick == 0) return DELAY_W'($urandom_range(0, WRAP_MS - 1));
        if (pick == 4) return '0;
        return DELAY_W'(WRAP_MS * pick);
      end
    endcase
  endfunction

  // Random command mix, with arm-and-wait runs so that channels really fire.
  task automatic random_phase(input int n, input delay_mix_t mix);
    int               sent;
    int               w;
    int               burst;
    logic [CMD_W-1:0] op;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 5) == 0) begin
        send_cmd(CMD_ARM, pick_delay(mix), 1'b0, '0);
        burst = $urandom_range(8, 40);
        repeat (burst) send_cmd(CMD_TICK, DELAY_W'($urandom), 1'b0, '0);
        sent += burst + 1;
      end else begin
        w = $urandom_range(0, 99);
        if (w < 45)      op = CMD_TICK;
        else if (w < 60) op = CMD_ARM;
        else if (w < 67) op = CMD_READ;
        else if (w < 77) op = CMD_ACQUIRE;
        else if (w < 93) op = CMD_RELEASE;
        else             op = CMD_BAD_LO + CMD_W'($urandom_range(0, 2));
        send_cmd(op, (op == CMD_ARM) ? pick_delay(mix) : DELAY_W'($urandom), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ------------------------------------------------------------- main thread
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_PRESCALE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    out_tready <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state, error replies, then a stop-restart sequence in which all
    // four channels fire on the same tick.
    script.push_back(typed_row(CMD_READ, '0, 1'b1, '0, 1'b0));
    script.push_back(typed_row(CMD_TICK, '0, 1'b1, '0, 1'b0));
    script.push_back(typed_row(CMD_RELEASE, '0, 1'b0, '0, 1'b0));
    script.push_back(typed_row(CMD_BAD_LO, '0, 1'b0, '0, 1'b0));
    script.push_back(typed_row(CMD_BAD_LO + 3'd2, 16'hFFFF, 1'b0, '0, 1'b0));
    script.push_back(typed_row(CMD_ACQUIRE, '0, 1'b1, '0, 1'b1));
    script.push_back(typed_row(CMD_TICK, '0, 1'b1, 32'd1, 1'b1));
    script.push_back(typed_row(CMD_RELEASE, '0, 1'b1, 32'd1, 1'b0));
    script.push_back(reg_row(REG_TPM, 16'd0));
    script.push_back(reg_row(REG_MIN_DLY, 16'hFFFF));
    script.push_back(reg_row(REG_PRESCALE, 16'd0));
    script.push_back(typed_row(CMD_ACQUIRE, '0, 1'b1, '0, 1'b1));
    script.push_back(op_row(CMD_TICK, '0));
    script.push_back(op_row(CMD_TICK, '0));
    script.push_back(op_row(CMD_ARM, 16'hFFFF));
    script.push_back(op_row(CMD_ARM, 16'h0000));
    script.push_back(op_row(CMD_ARM, 16'h5A5A));
    script.push_back(op_row(CMD_ARM, 16'hA5A5));
    script.push_back(typed_row(CMD_ARM, 16'h0001, 1'b0, 32'd2, 1'b1));
    repeat (5) script.push_back(op_row(CMD_RELEASE, '0));
    script.push_back(op_row(CMD_TICK, '0));
    script.push_back(op_row(CMD_ACQUIRE, '0));
    script.push_back(op_row(CMD_TICK, '0));
    script.push_back(op_row(CMD_TICK, '0));

    foreach (script[k]) begin
      if (script[k].is_reg) begin
        settle();
        write_reg(script[k].reg_idx, script[k].reg_val);
      end else begin
        send_cmd(script[k].op, script[k].dly, script[k].typed, script[k].want);
      end
    end

    // Randomised phases under different timing settings.
    set_timing(16'd1, 16'd1, 16'd0);
    random_phase(110, DLY_UP_TO_31);
    set_timing(16'd3, 16'd2, 16'd4);
    random_phase(110, DLY_UP_TO_15);
    set_timing(16'd2, 16'd0, 16'hFFFF);
    random_phase(80, DLY_ANY);
    set_timing(16'd1, 16'd1024, 16'(WRAP_MS));
    random_phase(80, DLY_WRAPPING);
    set_timing(16'd4096, 16'd1, 16'd1);
    random_phase(50, DLY_UP_TO_15);

    // Saturate the user count, then release past zero.
    set_timing(16'h1FFF, 16'd32, 16'd1);
    repeat (258) send_cmd(CMD_ACQUIRE, DELAY_W'($urandom), 1'b0, '0);
    repeat (260) send_cmd(CMD_RELEASE, DELAY_W'($urandom), 1'b0, '0);

    // Closing phase at full rate on both sides.
    set_timing(16'd1, 16'd1, 16'd0);
    calm = 1'b1;
    random_phase(100, DLY_UP_TO_31);

    settle();
    repeat (4 * REPLY_LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold-off so the core backs up.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!long_hold_done && replies_seen >= 60) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (120) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ----------------------------------------------------------------- checking
  task automatic check_field(input string what, input logic [NOW_W-1:0] want,
                             input logic [NOW_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      error_count++;
    end
  endtask

  // Each reply transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      replies_seen++;
      if (replies_due.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none, actual %0h", $time, got);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("ok", want.ok, got.ok);
        check_field("channel", want.chan, got.chan);
        check_field("fired_mask", want.fired, got.fired);
        check_field("now_count", want.now, got.now);
        check_field("running", want.running, got.running);
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
